FILE: src/fcpd_pkg.sv
// Shared types and constants for the framed packet deframer.
// Used by the configuration registers, the parser and the top level.
`timescale 1ns / 1ps

package fcpd_pkg;

	// Configuration register indexes.
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_SYNC_FIRST  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SYNC_SECOND = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_LEN     = 2'd2;

	// Reset values of the configuration registers.
	localparam logic [7:0] SYNC_FIRST_RST  = 8'd0;
	localparam logic [7:0] SYNC_SECOND_RST = 8'd0;
	localparam logic [7:0] MAX_LEN_RST     = 8'd255;

	// Parser phases; the two unused codes behave as hunting.
	typedef enum logic [2:0] {
		PH_START1 = 3'd0,
		PH_START2 = 3'd1,
		PH_LENGTH = 3'd2,
		PH_DATA   = 3'd3,
		PH_CHECK1 = 3'd4,
		PH_CHECK2 = 3'd5
	} phase_t;

	// Event codes reported with each result word.
	typedef enum logic [2:0] {
		EV_NONE     = 3'd0,
		EV_DATA     = 3'd1,
		EV_GOOD     = 3'd2,
		EV_MISMATCH = 3'd3,
		EV_BADLEN   = 3'd4
	} event_t;

	// Current configuration as seen by the parser.
	typedef struct packed {
		logic [7:0] sync_first;
		logic [7:0] sync_second;
		logic [7:0] max_len;
	} cfg_t;

	// One result word.
	typedef struct packed {
		event_t     ev;
		logic [7:0] data;
		logic [7:0] idx;
		logic [7:0] plen;
	} result_t;

endpackage

FILE: src/fcpd_cfg.sv
// Configuration register file of the framed packet deframer.
// Depends on fcpd_pkg for register indexes and the cfg_t struct.
`timescale 1ns / 1ps

module fcpd_cfg (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [fcpd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [7:0]                    cfg_data,
	output fcpd_pkg::cfg_t                cfg
);
	import fcpd_pkg::*;

	logic [7:0] sync_first_q;
	logic [7:0] sync_second_q;
	logic [7:0] max_len_q;

	// Decode the index and load the addressed register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_first_q  <= SYNC_FIRST_RST;
			sync_second_q <= SYNC_SECOND_RST;
			max_len_q     <= MAX_LEN_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_SYNC_FIRST:  sync_first_q  <= cfg_data;
				CFG_SYNC_SECOND: sync_second_q <= cfg_data;
				CFG_MAX_LEN:     max_len_q     <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg.sync_first  = sync_first_q;
	assign cfg.sync_second = sync_second_q;
	assign cfg.max_len     = max_len_q;

endmodule

FILE: src/fcpd_parse.sv
// Frame parser: phase state machine, length check and the two running sums.
// Depends on fcpd_pkg for phases, events, cfg_t and result_t.
`timescale 1ns / 1ps

module fcpd_parse (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  logic [7:0]        rx_byte,
	input  fcpd_pkg::cfg_t    cfg,
	output fcpd_pkg::result_t res
);
	import fcpd_pkg::*;

	phase_t     phase_q, phase_d;
	logic [7:0] exp_q, exp_d;
	logic [7:0] cnt_q, cnt_d;
	logic [7:0] run_q, run_d;
	logic [7:0] sos_q, sos_d;
	logic [7:0] run_sum;
	logic [7:0] cnt_inc;

	// State registers advance only when a word moves to the result stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_START1;
			exp_q   <= 8'd0;
			cnt_q   <= 8'd0;
			run_q   <= 8'd0;
			sos_q   <= 8'd0;
		end else if (step) begin
			phase_q <= phase_d;
			exp_q   <= exp_d;
			cnt_q   <= cnt_d;
			run_q   <= run_d;
			sos_q   <= sos_d;
		end
	end

	assign run_sum = run_q + rx_byte;
	assign cnt_inc = cnt_q + 8'd1;

	// Next phase, sums and the result word for the byte at hand.
	always_comb begin
		phase_d  = phase_q;
		exp_d    = exp_q;
		cnt_d    = cnt_q;
		run_d    = run_q;
		sos_d    = sos_q;
		res.ev   = EV_NONE;
		res.data = 8'd0;
		res.idx  = 8'd0;
		res.plen = 8'd0;
		unique case (phase_q)
			PH_START2: begin
				phase_d = (rx_byte == cfg.sync_second) ? PH_LENGTH : PH_START1;
			end
			PH_LENGTH: begin
				exp_d = rx_byte;
				if (rx_byte == 8'd0 || rx_byte > cfg.max_len) begin
					phase_d  = PH_START1;
					res.ev   = EV_BADLEN;
					res.plen = rx_byte;
				end else begin
					cnt_d   = 8'd0;
					run_d   = rx_byte;
					sos_d   = rx_byte;
					phase_d = PH_DATA;
				end
			end
			PH_DATA: begin
				res.ev   = EV_DATA;
				res.data = rx_byte;
				res.idx  = cnt_q;
				res.plen = exp_q;
				cnt_d    = cnt_inc;
				run_d    = run_sum;
				sos_d    = sos_q + run_sum;
				if (cnt_inc >= exp_q) begin
					phase_d = PH_CHECK1;
				end
			end
			PH_CHECK1: begin
				if (rx_byte == run_q) begin
					phase_d = PH_CHECK2;
				end else begin
					phase_d  = PH_START1;
					res.ev   = EV_MISMATCH;
					res.plen = exp_q;
				end
			end
			PH_CHECK2: begin
				phase_d  = PH_START1;
				res.ev   = (rx_byte == sos_q) ? EV_GOOD : EV_MISMATCH;
				res.plen = exp_q;
			end
			default: begin
				phase_d = (rx_byte == cfg.sync_first) ? PH_START2 : PH_START1;
			end
		endcase
	end

	// While in the payload the count always stays below the declared length.
	a_cnt_below_len: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_DATA) |-> (cnt_q < exp_q))
		else $error("payload count reached declared length inside payload");

	// An accepted length seeds both sums with that length.
	a_len_seeds_sums: assert property (@(posedge clk) disable iff (!arst_n)
		(step && phase_q == PH_LENGTH && res.ev == EV_NONE)
		|=> (phase_q == PH_DATA && run_q == exp_q && sos_q == exp_q && cnt_q == 8'd0))
		else $error("accepted length did not seed the payload sums");

endmodule

FILE: src/fletcher_checked_packet_deframer_unit.sv
// Top level of the framed packet deframer: input register, parser, result register.
// Depends on fcpd_pkg, fcpd_cfg and fcpd_parse.
//
//   channel   dir   handshake            payload
//   input     in    in_valid / in_stall    rx_byte
//   result    out   out_valid / out_stall  event_res, data_byte, byte_index, packet_length
//   config    in    cfg_we                 cfg_index, cfg_data
//
// Each byte passes through the input register, then the parser logic feeds the result
// register. One word per cycle is sustained while the result side does not stall.
// Reset clears the valid flags and the parser state and loads the configuration reset values.
// A stalled result holds the result register; the input register then refills once
// and stalls the input side until the result is taken.
`timescale 1ns / 1ps

module fletcher_checked_packet_deframer_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [7:0]                    rx_byte,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [2:0]                    event_res,
	output logic [7:0]                    data_byte,
	output logic [7:0]                    byte_index,
	output logic [7:0]                    packet_length,
	input  logic                          cfg_we,
	input  logic [fcpd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [7:0]                    cfg_data
);
	import fcpd_pkg::*;

	cfg_t       cfg;
	result_t    res;
	result_t    res_s2;
	logic [7:0] rx_byte_s1;
	logic       vld_s1;
	logic       vld_s2;
	logic       adv;
	logic       in_acc;

	// Handshake between the two register stages.
	assign adv      = vld_s1 && (!vld_s2 || !out_stall);
	assign in_stall = vld_s1 && !adv;
	assign in_acc   = in_valid && !in_stall;

	// Configuration registers.
	fcpd_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// Parser works on the word held in the input register.
	fcpd_parse u_parse (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (adv),
		.rx_byte (rx_byte_s1),
		.cfg     (cfg),
		.res     (res)
	);

	// Input register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_acc) begin
			vld_s1 <= 1'b1;
		end else if (adv) begin
			vld_s1 <= 1'b0;
		end
	end

	// Input register payload.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			rx_byte_s1 <= rx_byte;
		end
	end

	// Result register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (adv) begin
			vld_s2 <= 1'b1;
		end else if (!out_stall) begin
			vld_s2 <= 1'b0;
		end
	end

	// Result register payload.
	always_ff @(posedge clk) begin
		if (adv) begin
			res_s2 <= res;
		end
	end

	assign out_valid     = vld_s2;
	assign event_res     = res_s2.ev;
	assign data_byte     = res_s2.data;
	assign byte_index    = res_s2.idx;
	assign packet_length = res_s2.plen;

	// The input side is only held off when both stages are full and the output stalls.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (vld_s1 && vld_s2 && out_stall))
		else $error("input stalled without a blocked result stage");

	// A word that cannot advance stays in the input register unchanged.
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s1 && !adv) |=> (vld_s1 && $stable(rx_byte_s1)))
		else $error("input register lost a word that had not advanced");

endmodule

FILE: dv/deframe_checker.sv
// Checker for the framed packet deframer: watches the byte, result and register ports,
// predicts every result word and compares it field by field with what the block returns.
// Depends on fcpd_pkg for the phase, event and result types and the register indexes.
`timescale 1ns / 1ps

module deframe_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	input  logic                           in_stall,
	input  logic [7:0]                     rx_byte,
	input  logic                           out_valid,
	input  logic                           out_stall,
	input  logic [2:0]                     event_res,
	input  logic [7:0]                     data_byte,
	input  logic [7:0]                     byte_index,
	input  logic [7:0]                     packet_length,
	input  logic                           cfg_we,
	input  logic [fcpd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [7:0]                     cfg_data,
	output int                             pending,
	output int                             fail_count
);
	import fcpd_pkg::*;

	// Register copy as the block should hold it.
	logic [7:0] sync_a;
	logic [7:0] sync_b;
	logic [7:0] max_len;

	// Parser state of the predictor.
	phase_t     ph;
	logic [7:0] exp_len;
	logic [7:0] rx_cnt;
	logic [7:0] sum_a;
	logic [7:0] sum_b;

	// Result words predicted but not yet returned, oldest first.
	result_t    deframe_results[$];
	int         mism = 0;

	assign fail_count = mism;

	// Advance the parser by one received byte and return the word it reports.
	function automatic result_t deframe_byte(input logic [7:0] b);
		result_t r;
		r.ev   = EV_NONE;
		r.data = 8'd0;
		r.idx  = 8'd0;
		r.plen = 8'd0;
		case (ph)
			PH_START2: begin
				// A wrong second start byte is not retried as a first one.
				ph = (b == sync_b) ? PH_LENGTH : PH_START1;
			end
			PH_LENGTH: begin
				exp_len = b;
				if (b == 8'd0 || b > max_len) begin
					ph     = PH_START1;
					r.ev   = EV_BADLEN;
					r.plen = b;
				end else begin
					// Both sums start from the length itself.
					rx_cnt = 8'd0;
					sum_a  = b;
					sum_b  = b;
					ph     = PH_DATA;
				end
			end
			PH_DATA: begin
				r.ev   = EV_DATA;
				r.data = b;
				r.idx  = rx_cnt;
				r.plen = exp_len;
				rx_cnt = rx_cnt + 8'd1;
				sum_a  = sum_a + b;
				sum_b  = sum_b + sum_a;
				if (rx_cnt >= exp_len)
					ph = PH_CHECK1;
			end
			PH_CHECK1: begin
				if (b == sum_a) begin
					ph = PH_CHECK2;
				end else begin
					ph     = PH_START1;
					r.ev   = EV_MISMATCH;
					r.plen = exp_len;
				end
			end
			PH_CHECK2: begin
				ph     = PH_START1;
				r.ev   = (b == sum_b) ? EV_GOOD : EV_MISMATCH;
				r.plen = exp_len;
			end
			default: begin
				ph = (b == sync_a) ? PH_START2 : PH_START1;
			end
		endcase
		return r;
	endfunction

	// Results are checked before the byte accepted at the same edge is predicted,
	// since a word can never leave in the cycle its byte enters.
	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			sync_a  = SYNC_FIRST_RST;
			sync_b  = SYNC_SECOND_RST;
			max_len = MAX_LEN_RST;
			ph      = PH_START1;
			exp_len = 8'd0;
			rx_cnt  = 8'd0;
			sum_a   = 8'd0;
			sum_b   = 8'd0;
			deframe_results.delete();
			pending <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (deframe_results.size() == 0) begin
					if (mism < 10)
						$display("%0t: unexpected result word ev=%0d data=%02h idx=%0d len=%0d",
							$time, event_res, data_byte, byte_index, packet_length);
					mism++;
				end else begin
					want = deframe_results.pop_front();
					if (event_res !== want.ev || data_byte !== want.data ||
						byte_index !== want.idx || packet_length !== want.plen) begin
						if (mism < 10) begin
							$write("%0t: result mismatch, expected ev=%0d data=%02h idx=%0d len=%0d, ",
								$time, want.ev, want.data, want.idx, want.plen);
							$display("got ev=%0d data=%02h idx=%0d len=%0d",
								event_res, data_byte, byte_index, packet_length);
						end
						mism++;
					end
				end
			end

			// Register writes take effect from the next byte on.
			if (cfg_we) begin
				case (cfg_index)
					CFG_SYNC_FIRST:  sync_a  = cfg_data;
					CFG_SYNC_SECOND: sync_b  = cfg_data;
					CFG_MAX_LEN:     max_len = cfg_data;
					default: ;
				endcase
			end

			if (in_valid && !in_stall)
				deframe_results.push_back(deframe_byte(rx_byte));

			pending <= deframe_results.size();
		end
	end

endmodule

FILE: dv/tb_top.sv
// Top of the deframer testbench: clock, reset, register setup, byte stimulus and verdict.
// Depends on fcpd_pkg, the deframer top level and deframe_checker, which does the checking.
`timescale 1ns / 1ps

module tb_top;
	import fcpd_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int HOLD_CYCLES = 300;
	localparam int DRAIN_CYCLES = 4;
	// Index with no register behind it; writes there must change nothing.
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

	typedef enum {FR_GOOD, FR_BAD_CHECK1, FR_BAD_CHECK2, FR_BAD_LEN, FR_BAD_SYNC} frame_kind_t;

	logic                 clk;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_stall;
	logic [7:0]           rx_byte;
	logic                 out_valid;
	logic                 out_stall;
	logic [2:0]           event_res;
	logic [7:0]           data_byte;
	logic [7:0]           byte_index;
	logic [7:0]           packet_length;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [7:0]           cfg_data;

	int                   pending;
	int                   fail_count;
	int                   cycles = 0;
	int                   snd_idle_pct = 0;
	int                   rcv_idle_pct = 0;
	bit                   hold_go = 1'b0;

	// Bytes waiting to be sent, and the register values the frames are built for.
	logic [7:0]           tx_bytes[$];
	logic [7:0]           cur_sync_a;
	logic [7:0]           cur_sync_b;
	logic [7:0]           cur_max;

	fletcher_checked_packet_deframer_unit DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.rx_byte(rx_byte),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.event_res(event_res),
		.data_byte(data_byte),
		.byte_index(byte_index),
		.packet_length(packet_length),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	deframe_checker u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.rx_byte(rx_byte),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.event_res(event_res),
		.data_byte(data_byte),
		.byte_index(byte_index),
		.packet_length(packet_length),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.pending(pending),
		.fail_count(fail_count)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Watchdog on the total run length.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// Result side: random stalls, or one long hold-off when asked for.
	initial begin
		bit held;
		held = 1'b0;
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_go && !held) begin
				held = 1'b1;
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			out_stall <= ($urandom_range(0, 99) < rcv_idle_pct);
		end
	end

	// Write all three registers, then the spare index, while the block is idle.
	task automatic program_regs(input logic [7:0] a, input logic [7:0] b, input logic [7:0] m);
		cur_sync_a = a;
		cur_sync_b = b;
		cur_max    = m;
		cfg_we    <= 1'b1;
		cfg_index <= CFG_SYNC_FIRST;
		cfg_data  <= a;
		@(posedge clk);
		cfg_index <= CFG_SYNC_SECOND;
		cfg_data  <= b;
		@(posedge clk);
		cfg_index <= CFG_MAX_LEN;
		cfg_data  <= m;
		@(posedge clk);
		cfg_index <= CFG_SPARE;
		cfg_data  <= 8'($urandom);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Queue one frame; pay below zero means random payload bytes.
	task automatic add_frame(input frame_kind_t kind, input int len, input int pay);
		logic [7:0] run_sum;
		logic [7:0] sum_sum;
		logic [7:0] b;
		tx_bytes.push_back(cur_sync_a);
		if (kind == FR_BAD_SYNC) begin
			tx_bytes.push_back(cur_sync_b ^ 8'($urandom_range(1, 255)));
			return;
		end
		tx_bytes.push_back(cur_sync_b);
		if (kind == FR_BAD_LEN) begin
			if (cur_max == 8'd255 || $urandom_range(0, 3) == 0)
				b = 8'd0;
			else
				b = 8'($urandom_range(int'(cur_max) + 1, 255));
			tx_bytes.push_back(b);
			return;
		end
		run_sum = 8'(len);
		sum_sum = 8'(len);
		tx_bytes.push_back(8'(len));
		for (int i = 0; i < len; i++) begin
			b = (pay < 0) ? 8'($urandom) : 8'(pay);
			run_sum = run_sum + b;
			sum_sum = sum_sum + run_sum;
			tx_bytes.push_back(b);
		end
		if (kind == FR_BAD_CHECK1)
			run_sum = run_sum ^ 8'($urandom_range(1, 255));
		if (kind == FR_BAD_CHECK2)
			sum_sum = sum_sum ^ 8'($urandom_range(1, 255));
		tx_bytes.push_back(run_sum);
		tx_bytes.push_back(sum_sum);
	endtask

	// Mostly well-formed frames of small length, with line noise and broken frames mixed in.
	task automatic fill_random(input int target);
		int roll;
		int len;
		int hi;
		while (tx_bytes.size() < target) begin
			if ($urandom_range(0, 99) < 25)
				repeat ($urandom_range(1, 3)) tx_bytes.push_back(8'($urandom));
			hi = (cur_max == 8'd0) ? 8 : ((cur_max < 8'd12) ? int'(cur_max) : 12);
			len = $urandom_range(1, hi);
			if (cur_max != 8'd0 && cur_max <= 8'd40 && $urandom_range(0, 99) < 5)
				len = cur_max;
			roll = $urandom_range(0, 99);
			if (roll < 70)
				add_frame(FR_GOOD, len, -1);
			else if (roll < 80)
				add_frame(FR_BAD_CHECK1, len, -1);
			else if (roll < 88)
				add_frame(FR_BAD_CHECK2, len, -1);
			else if (roll < 94)
				add_frame(FR_BAD_LEN, len, -1);
			else
				add_frame(FR_BAD_SYNC, len, -1);
		end
	endtask

	// Send every queued byte as one word each, then wait until all results are back.
	task automatic run_bytes();
		logic [7:0] b;
		while (tx_bytes.size() != 0) begin
			b = tx_bytes.pop_front();
			while ($urandom_range(0, 99) < snd_idle_pct) begin
				in_valid <= 1'b0;
				@(posedge clk);
			end
			in_valid <= 1'b1;
			rx_byte  <= b;
			@(posedge clk);
			while (in_stall) @(posedge clk);
		end
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	initial begin
		arst_n    <= 1'b0;
		in_valid  <= 1'b0;
		rx_byte   <= 8'd0;
		cfg_we    <= 1'b0;
		cfg_index <= CFG_SYNC_FIRST;
		cfg_data  <= 8'd0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed frames first, then a full-length packet and random traffic.
		snd_idle_pct = 28;
		rcv_idle_pct = 70;
		program_regs(8'hA5, 8'h5A, 8'd255);
		add_frame(FR_GOOD, 1, 8'hFF);
		add_frame(FR_BAD_SYNC, 0, -1);
		add_frame(FR_BAD_LEN, 0, -1);
		add_frame(FR_BAD_CHECK1, 2, 8'h00);
		add_frame(FR_BAD_CHECK2, 1, 8'h00);
		add_frame(FR_GOOD, 255, -1);
		fill_random(tx_bytes.size() + 100);
		run_bytes();

		// Maximum length of one, start bytes at both extremes.
		snd_idle_pct = 70;
		rcv_idle_pct = 28;
		program_regs(8'h00, 8'hFF, 8'd1);
		fill_random(200);
		run_bytes();

		// A zero maximum rejects every length; both start bytes equal.
		snd_idle_pct = 0;
		rcv_idle_pct = 0;
		program_regs(8'h7E, 8'h7E, 8'd0);
		fill_random(50);
		run_bytes();

		// Random setting; the result side holds off first so the block backs up.
		program_regs(8'($urandom), 8'($urandom), 8'($urandom_range(8, 40)));
		fill_random(260);
		hold_go = 1'b1;
		run_bytes();

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
